[hw/rtl/stl_pkg.sv]
`timescale 1ns / 1ps

package stl_pkg;

	localparam int POS_BITS    = 24;
	localparam int LEN_BITS    = 16;
	localparam int QUEUE_DEPTH = 4;

	// character codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_V  = 8'h76;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_Z  = 8'h7a;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5a;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// token kinds
	localparam logic [4:0] K_VAR    = 5'd0;
	localparam logic [4:0] K_IDENT  = 5'd1;
	localparam logic [4:0] K_SEMI   = 5'd2;
	localparam logic [4:0] K_COLON  = 5'd3;
	localparam logic [4:0] K_LPAREN = 5'd4;
	localparam logic [4:0] K_RPAREN = 5'd5;
	localparam logic [4:0] K_LBRACE = 5'd6;
	localparam logic [4:0] K_RBRACE = 5'd7;
	localparam logic [4:0] K_PLUS   = 5'd8;
	localparam logic [4:0] K_MINUS  = 5'd11;
	localparam logic [4:0] K_STAR   = 5'd14;
	localparam logic [4:0] K_SLASH  = 5'd16;
	localparam logic [4:0] K_ASSIGN = 5'd18;
	localparam logic [4:0] K_GT     = 5'd20;
	localparam logic [4:0] K_LT     = 5'd22;
	localparam logic [4:0] K_NUMBER = 5'd24;
	localparam logic [4:0] K_STRING = 5'd25;
	localparam logic [4:0] K_CHAR   = 5'd26;
	localparam logic [4:0] K_END    = 5'd27;
	localparam logic [4:0] K_ERROR  = 5'd28;
	localparam logic [4:0] K_NONE   = 5'd0;

	// offsets from an operator's base kind
	localparam logic [4:0] OP_WITH_EQ  = 5'd1;
	localparam logic [4:0] OP_DOUBLED  = 5'd2;

	localparam logic [1:0] E_NONE          = 2'd0;
	localparam logic [1:0] E_UNEXPECTED    = 2'd1;
	localparam logic [1:0] E_UNTERM_STRING = 2'd2;
	localparam logic [1:0] E_MISSING_QUOTE = 2'd3;

	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_HASH  = 4'd1,
		M_FNAME = 4'd2,
		M_IDENT = 4'd3,
		M_OP    = 4'd4,
		M_NUMI  = 4'd5,
		M_NUMF  = 4'd6,
		M_STR   = 4'd7,
		M_CH1   = 4'd8,
		M_CH2   = 4'd9,
		M_SYNC  = 4'd10
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} src_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [1:0]  error_code;
		logic [23:0] start_pos;
		logic [15:0] token_len;
		logic [15:0] line_no;
		logic [7:0]  file_index;
		logic        last;
	} tok_t;

	// results of one source byte, up to two
	typedef struct packed {
		logic two;
		tok_t first;
		tok_t second;
	} pair_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c == CH_UNDER || (c >= CH_LOW_A && c <= CH_LOW_Z) ||
			(c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic logic is_opch(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_EQ || c == CH_GT || c == CH_LT;
	endfunction

	function automatic logic [4:0] op_base(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			CH_PLUS:  k = K_PLUS;
			CH_MINUS: k = K_MINUS;
			CH_STAR:  k = K_STAR;
			CH_SLASH: k = K_SLASH;
			CH_EQ:    k = K_ASSIGN;
			CH_GT:    k = K_GT;
			default:  k = K_LT;
		endcase
		return k;
	endfunction

	// K_NONE when the byte is no punctuation
	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			CH_SEMI:   k = K_SEMI;
			CH_COLON:  k = K_COLON;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			default:   k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

[hw/rtl/source_token_lexer_top.sv]
`timescale 1ns / 1ps
// a token passes from the byte that ends it through the token queue and then the output register
//   before it is shown on tok_*
// throughput: one source byte per cycle while the token queue has room; the output register shows one
//   token per cycle while tok_ready allows, so a byte giving two tokens shows them in turn, absorbed by the token queue
// src_ready falls only when the token queue is full
// reset (arst_n low): idle mode, offset 0, line 1, file index 0, queue and output empty

module source_token_lexer_top #(
	parameter int PosBits = stl_pkg::POS_BITS,
	parameter int LenBits = stl_pkg::LEN_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_ready,
	input  stl_pkg::src_t src_item,
	output logic          tok_valid,
	input  logic          tok_ready,
	output stl_pkg::tok_t tok_item
);
	import stl_pkg::*;

	logic  room, push, pop, empty;
	pair_t push_item, head;

	stl_front #(
		.PosBits(PosBits),
		.LenBits(LenBits)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.room      (room),
		.push      (push),
		.push_item (push_item)
	);

	stl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (push_item),
		.room    (room),
		.rd_en   (pop),
		.rd_item (head),
		.empty   (empty)
	);

	stl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule

[hw/rtl/stl_front.sv]
`timescale 1ns / 1ps

module stl_front #(
	parameter int PosBits = stl_pkg::POS_BITS,
	parameter int LenBits = stl_pkg::LEN_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_ready,
	input  stl_pkg::src_t  src_item,
	input  logic           room,
	output logic           push,
	output stl_pkg::pair_t push_item
);
	import stl_pkg::*;

	mode_t               mode_q, n_mode, i_mode;
	logic [7:0]          pend_q, n_pend;
	logic [PosBits-1:0]  start_q, n_start, i_start;
	logic [LenBits-1:0]  len_q, n_len, i_len, len_inc;
	logic [PosBits-1:0]  pos_q;
	logic [15:0]         line_q;
	logic [7:0]          file_q, n_file;
	logic [1:0]          kp_q, n_kp;
	logic                sync_q, n_sync;

	logic [7:0]          c;
	logic                acc, eoi;
	logic                i_tok, i_kp_set, i_pend_set, i_err, i_emit;
	logic [4:0]          i_kind, a_kind, op_k;
	logic [1:0]          i_code, a_code;
	logic                a_v, b_v, relex;
	logic [PosBits-1:0]  a_start;
	logic [LenBits-1:0]  a_len;
	tok_t                tok_a, tok_b;

	assign c         = src_item.ch;
	assign eoi       = src_item.end_of_input;
	assign src_ready = room;
	assign acc       = src_valid && room;
	assign len_inc   = (len_q == '1) ? len_q : len_q + 1'b1;
	assign op_k      = op_base(pend_q);

	// what the byte does when lexed from idle
	always_comb begin
		i_mode     = M_IDLE;
		i_tok      = 1'b0;
		i_start    = pos_q;
		i_len      = LenBits'(1);
		i_kp_set   = 1'b0;
		i_pend_set = 1'b0;
		i_err      = 1'b0;
		i_emit     = 1'b0;
		i_kind     = K_ERROR;
		i_code     = E_NONE;
		if (is_ws(c)) begin
			i_mode = M_IDLE;
		end else if (c == CH_HASH) begin
			i_mode = M_HASH;
		end else if (is_alpha(c)) begin
			i_mode   = M_IDENT;
			i_tok    = 1'b1;
			i_kp_set = 1'b1;
		end else if (punct_kind(c) != K_NONE) begin
			i_emit = 1'b1;
			i_kind = punct_kind(c);
		end else if (is_opch(c)) begin
			i_mode     = M_OP;
			i_tok      = 1'b1;
			i_pend_set = 1'b1;
		end else if (is_digit(c)) begin
			i_mode = M_NUMI;
			i_tok  = 1'b1;
		end else if (c == CH_DOT) begin
			i_mode = M_NUMF;
			i_tok  = 1'b1;
		end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
			i_mode  = (c == CH_DQUOTE) ? M_STR : M_CH1;
			i_tok   = 1'b1;
			i_start = pos_q + 1'b1;
			i_len   = '0;
		end else begin
			i_mode = M_SYNC;
			i_emit = 1'b1;
			i_code = E_UNEXPECTED;
			i_err  = 1'b1;
		end
	end

	always_comb begin
		n_mode  = mode_q;
		n_pend  = pend_q;
		n_start = start_q;
		n_len   = len_q;
		n_file  = file_q;
		n_kp    = kp_q;
		n_sync  = sync_q;
		a_v     = 1'b0;
		a_kind  = K_ERROR;
		a_code  = E_NONE;
		a_start = start_q;
		a_len   = len_q;
		b_v     = 1'b0;
		relex   = 1'b0;
		if (eoi) begin
			case (mode_q)
				M_IDENT: begin
					a_v    = 1'b1;
					a_kind = K_IDENT;
				end
				M_NUMI, M_NUMF: begin
					a_v    = 1'b1;
					a_kind = K_NUMBER;
				end
				M_OP: begin
					a_v    = 1'b1;
					a_kind = op_k;
					a_len  = LenBits'(1);
				end
				M_STR: begin
					a_v    = 1'b1;
					a_code = E_UNTERM_STRING;
				end
				M_CH1, M_CH2: begin
					a_v    = 1'b1;
					a_code = E_MISSING_QUOTE;
				end
				default: a_v = 1'b0;
			endcase
			b_v    = 1'b1;
			n_mode = M_IDLE;
			n_sync = 1'b0;
			n_kp   = 2'd0;
		end else begin
			case (mode_q)
				M_HASH: begin
					if (c == CH_LOW_F) begin
						n_mode = M_FNAME;
						n_file = file_q + 1'b1;
					end else begin
						n_mode = M_IDLE;
					end
				end
				M_FNAME: begin
					if (is_ws(c))
						n_mode = M_IDLE;
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						n_len = len_inc;
						if (kp_q == 2'd1 && c == CH_LOW_A)
							n_kp = 2'd2;
						else if (kp_q == 2'd2 && c == CH_LOW_R)
							n_kp = 2'd3;
						else
							n_kp = 2'd0;
					end else begin
						a_v    = 1'b1;
						a_kind = (kp_q == 2'd3 && is_ws(c)) ? K_VAR : K_IDENT;
						n_kp   = 2'd0;
						relex  = 1'b1;
					end
				end
				M_OP: begin
					a_v   = 1'b1;
					n_mode = M_IDLE;
					a_len = LenBits'(2);
					if (c == CH_EQ) begin
						a_kind = op_k + OP_WITH_EQ;
					end else if ((pend_q == CH_PLUS || pend_q == CH_MINUS) &&
							c == pend_q) begin
						a_kind = op_k + OP_DOUBLED;
					end else begin
						a_kind = op_k;
						a_len  = LenBits'(1);
						relex  = 1'b1;
					end
				end
				M_NUMI, M_NUMF: begin
					if (is_digit(c)) begin
						n_len = len_inc;
					end else if (c == CH_DOT && mode_q == M_NUMI) begin
						n_len  = len_inc;
						n_mode = M_NUMF;
					end else begin
						a_v    = 1'b1;
						a_kind = K_NUMBER;
						relex  = 1'b1;
					end
				end
				M_STR: begin
					if (c == CH_DQUOTE) begin
						a_v    = 1'b1;
						a_kind = K_STRING;
						n_mode = M_IDLE;
					end else begin
						n_len = len_inc;
					end
				end
				M_CH1: begin
					n_len  = LenBits'(1);
					n_mode = M_CH2;
				end
				M_CH2: begin
					a_v = 1'b1;
					if (c == CH_SQUOTE) begin
						a_kind = K_CHAR;
						a_len  = LenBits'(1);
						n_mode = M_IDLE;
					end else begin
						// the offending byte is the first one looked at in resync
						a_code = E_MISSING_QUOTE;
						n_mode = M_SYNC;
						n_sync = (c == CH_DQUOTE);
						if (c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE || c == CH_LF)
							n_mode = M_IDLE;
					end
				end
				M_SYNC: begin
					if (c == CH_DQUOTE)
						n_sync = !sync_q;
					else if (!sync_q && (c == CH_SEMI || c == CH_LBRACE ||
							c == CH_RBRACE || c == CH_LF))
						n_mode = M_IDLE;
				end
				default: relex = 1'b1;
			endcase
			if (relex) begin
				n_mode = i_mode;
				if (i_tok) begin
					n_start = i_start;
					n_len   = i_len;
				end
				if (i_kp_set)
					n_kp = (c == CH_LOW_V) ? 2'd1 : 2'd0;
				if (i_pend_set)
					n_pend = c;
				if (i_err)
					n_sync = 1'b0;
				b_v = i_emit;
			end
		end
	end

	always_comb begin
		tok_a.token_kind = a_kind;
		tok_a.error_code = a_code;
		tok_a.start_pos  = 24'(a_start);
		tok_a.token_len  = 16'(a_len);
		tok_a.line_no    = line_q;
		tok_a.file_index = file_q;
		tok_a.last       = !b_v;
		tok_b.line_no    = line_q;
		tok_b.file_index = file_q;
		tok_b.last       = 1'b1;
		if (eoi) begin
			tok_b.token_kind = K_END;
			tok_b.error_code = E_NONE;
			tok_b.start_pos  = 24'(pos_q);
			tok_b.token_len  = '0;
		end else begin
			tok_b.token_kind = i_kind;
			tok_b.error_code = i_code;
			tok_b.start_pos  = 24'(pos_q);
			tok_b.token_len  = 16'(LenBits'(1));
		end
		push             = acc && (a_v || b_v);
		push_item.two    = a_v && b_v;
		push_item.first  = a_v ? tok_a : tok_b;
		push_item.second = tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pend_q  <= '0;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			line_q  <= 16'd1;
			file_q  <= '0;
			kp_q    <= '0;
			sync_q  <= 1'b0;
		end else if (acc) begin
			mode_q  <= n_mode;
			pend_q  <= n_pend;
			start_q <= n_start;
			len_q   <= n_len;
			file_q  <= n_file;
			kp_q    <= n_kp;
			sync_q  <= n_sync;
			if (!eoi) begin
				pos_q <= pos_q + 1'b1;
				if (c == CH_LF && line_q != 16'hffff)
					line_q <= line_q + 1'b1;
			end
		end
	end

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !eoi |=> pos_q == PosBits'($past(pos_q) + 1'b1))
		else $error("byte offset did not advance by one");

endmodule

[hw/rtl/stl_queue.sv]
`timescale 1ns / 1ps

module stl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  stl_pkg::pair_t wr_item,
	output logic           room,
	input  logic           rd_en,
	output stl_pkg::pair_t rd_item,
	output logic           empty
);
	import stl_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	pair_t         slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          full;

	assign full    = cnt_q == CW'(QUEUE_DEPTH);
	assign room    = !full;
	assign empty   = cnt_q == '0;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en)
		else $error("write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !rd_en)
		else $error("read from an empty queue");

endmodule

[hw/rtl/stl_back.sv]
`timescale 1ns / 1ps

module stl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  stl_pkg::pair_t head,
	input  logic           empty,
	output logic           pop,
	output logic           tok_valid,
	input  logic           tok_ready,
	output stl_pkg::tok_t  tok_item
);
	import stl_pkg::*;

	tok_t out_q;
	logic valid_q;
	logic sel_q;
	logic take, load;

	assign take      = !valid_q || tok_ready;
	assign load      = take && !empty;
	// the head entry leaves once its last token has been loaded
	assign pop       = load && (sel_q || !head.two);
	assign tok_valid = valid_q;
	assign tok_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			sel_q   <= !sel_q && head.two;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= sel_q ? head.second : head.first;
	end

	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> valid_q && !out_q.last)
		else $error("first token of a pair shown without a follower pending");

endmodule

[sim/source_token_lexer_top_tb.sv]
`timescale 1ns / 1ps

module source_token_lexer_top_tb;
	import stl_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int RANDOM_BYTES   = 330;

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_ready;
	src_t src_item;
	logic tok_valid;
	logic tok_ready;
	tok_t tok_item;

	source_token_lexer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item(src_item),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_item(tok_item)
	);

	tok_t expected_toks[$];
	int   mismatches;
	int   bytes_sent;
	int   idle_cycles;
	bit   idle_on;
	bit   burst;

	// predicted lexer state
	mode_t       scan_mode;
	logic [7:0]  op_char;
	logic [23:0] tok_begin;
	logic [15:0] tok_size;
	logic [23:0] byte_pos;
	logic [15:0] line_num;
	logic [7:0]  file_num;
	logic [1:0]  var_match;
	logic        sync_quoted;
	tok_t        step_tok[2];
	int          step_n;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic bit is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
			c == CH_UNDER;
	endfunction

	function automatic logic [4:0] punct_kind_of(input logic [7:0] c);
		case (c)
			CH_SEMI:   return K_SEMI;
			CH_COLON:  return K_COLON;
			CH_LPAREN: return K_LPAREN;
			CH_RPAREN: return K_RPAREN;
			CH_LBRACE: return K_LBRACE;
			CH_RBRACE: return K_RBRACE;
			default:   return K_NONE;
		endcase
	endfunction

	// K_NONE for a byte that opens no operator
	function automatic logic [4:0] op_kind_of(input logic [7:0] c);
		case (c)
			CH_PLUS:  return K_PLUS;
			CH_MINUS: return K_MINUS;
			CH_STAR:  return K_STAR;
			CH_SLASH: return K_SLASH;
			CH_EQ:    return K_ASSIGN;
			CH_GT:    return K_GT;
			CH_LT:    return K_LT;
			default:  return K_NONE;
		endcase
	endfunction

	function automatic logic [15:0] grow(input logic [15:0] n);
		return (n == 16'hffff) ? n : n + 16'd1;
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// mostly short gaps, a few long ones, none while idling is off
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_token(input logic [4:0] kind, input logic [1:0] code,
			input logic [23:0] start, input logic [15:0] len);
		tok_t t;
		t.token_kind = kind;
		t.error_code = code;
		t.start_pos  = start;
		t.token_len  = len;
		t.line_no    = line_num;
		t.file_index = file_num;
		t.last       = 1'b0;
		if (step_n < 2) begin
			step_tok[step_n] = t;
			step_n++;
		end
	endtask

	task automatic start_token(input mode_t m, input logic [23:0] start,
			input logic [15:0] len);
		scan_mode = m;
		tok_begin = start;
		tok_size  = len;
	endtask

	task automatic lex_from_idle(input logic [7:0] c);
		if (is_blank(c)) begin
		end else if (c == CH_HASH) begin
			scan_mode = M_HASH;
		end else if (is_letter(c)) begin
			start_token(M_IDENT, byte_pos, 16'd1);
			var_match = (c == CH_LOW_V) ? 2'd1 : 2'd0;
		end else if (punct_kind_of(c) != K_NONE) begin
			add_token(punct_kind_of(c), E_NONE, byte_pos, 16'd1);
		end else if (op_kind_of(c) != K_NONE) begin
			start_token(M_OP, byte_pos, 16'd1);
			op_char = c;
		end else if (is_numeral(c)) begin
			start_token(M_NUMI, byte_pos, 16'd1);
		end else if (c == CH_DOT) begin
			start_token(M_NUMF, byte_pos, 16'd1);
		end else if (c == CH_DQUOTE) begin
			start_token(M_STR, byte_pos + 24'd1, 16'd0);
		end else if (c == CH_SQUOTE) begin
			start_token(M_CH1, byte_pos + 24'd1, 16'd0);
		end else begin
			add_token(K_ERROR, E_UNEXPECTED, byte_pos, 16'd1);
			scan_mode   = M_SYNC;
			sync_quoted = 1'b0;
		end
	endtask

	task automatic resync(input logic [7:0] c);
		if (c == CH_DQUOTE)
			sync_quoted = !sync_quoted;
		else if (!sync_quoted && (c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE ||
				c == CH_LF))
			scan_mode = M_IDLE;
	endtask

	task automatic lex_byte(input logic [7:0] c);
		logic [4:0] base;
		case (scan_mode)
			M_HASH: begin
				if (c == CH_LOW_F) begin
					scan_mode = M_FNAME;
					file_num++;
				end else begin
					scan_mode = M_IDLE;
				end
			end
			M_FNAME: begin
				if (is_blank(c))
					scan_mode = M_IDLE;
			end
			M_IDENT: begin
				if (is_letter(c) || is_numeral(c)) begin
					tok_size = grow(tok_size);
					if (var_match == 2'd1 && c == CH_LOW_A)
						var_match = 2'd2;
					else if (var_match == 2'd2 && c == CH_LOW_R)
						var_match = 2'd3;
					else
						var_match = 2'd0;
				end else begin
					// only whitespace after the word makes it the keyword
					add_token((var_match == 2'd3 && is_blank(c)) ? K_VAR : K_IDENT, E_NONE,
						tok_begin, tok_size);
					var_match = 2'd0;
					scan_mode = M_IDLE;
					lex_from_idle(c);
				end
			end
			M_OP: begin
				base      = op_kind_of(op_char);
				scan_mode = M_IDLE;
				if (c == CH_EQ) begin
					add_token(base + OP_WITH_EQ, E_NONE, tok_begin, 16'd2);
				end else if ((op_char == CH_PLUS || op_char == CH_MINUS) && c == op_char) begin
					add_token(base + OP_DOUBLED, E_NONE, tok_begin, 16'd2);
				end else begin
					add_token(base, E_NONE, tok_begin, 16'd1);
					lex_from_idle(c);
				end
			end
			M_NUMI, M_NUMF: begin
				if (is_numeral(c)) begin
					tok_size = grow(tok_size);
				end else if (c == CH_DOT && scan_mode == M_NUMI) begin
					tok_size  = grow(tok_size);
					scan_mode = M_NUMF;
				end else begin
					add_token(K_NUMBER, E_NONE, tok_begin, tok_size);
					scan_mode = M_IDLE;
					lex_from_idle(c);
				end
			end
			M_STR: begin
				if (c == CH_DQUOTE) begin
					add_token(K_STRING, E_NONE, tok_begin, tok_size);
					scan_mode = M_IDLE;
				end else begin
					tok_size = grow(tok_size);
				end
			end
			M_CH1: begin
				tok_size  = 16'd1;
				scan_mode = M_CH2;
			end
			M_CH2: begin
				if (c == CH_SQUOTE) begin
					add_token(K_CHAR, E_NONE, tok_begin, 16'd1);
					scan_mode = M_IDLE;
				end else begin
					// the byte in place of the quote is the first one resync looks at
					add_token(K_ERROR, E_MISSING_QUOTE, tok_begin, tok_size);
					scan_mode   = M_SYNC;
					sync_quoted = 1'b0;
					resync(c);
				end
			end
			M_SYNC: resync(c);
			default: begin
				scan_mode = M_IDLE;
				lex_from_idle(c);
			end
		endcase
	endtask

	task automatic flush_at_end();
		case (scan_mode)
			M_IDENT:        add_token(K_IDENT, E_NONE, tok_begin, tok_size);
			M_NUMI, M_NUMF: add_token(K_NUMBER, E_NONE, tok_begin, tok_size);
			M_OP:           add_token(op_kind_of(op_char), E_NONE, tok_begin, 16'd1);
			M_STR:          add_token(K_ERROR, E_UNTERM_STRING, tok_begin, tok_size);
			M_CH1, M_CH2:   add_token(K_ERROR, E_MISSING_QUOTE, tok_begin, tok_size);
			default: ;
		endcase
		add_token(K_END, E_NONE, byte_pos, 16'd0);
		scan_mode   = M_IDLE;
		sync_quoted = 1'b0;
		var_match   = 2'd0;
	endtask

	task automatic predict_tokens(input src_t s);
		step_n = 0;
		if (s.end_of_input) begin
			flush_at_end();
		end else begin
			lex_byte(s.ch);
			if (s.ch == CH_LF && line_num != 16'hffff)
				line_num++;
			byte_pos++;
		end
		if (step_n > 0)
			step_tok[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_toks.push_back(step_tok[i]);
	endtask

	// one source transaction; the prediction is made at the edge that takes it
	task automatic send_src(input logic [7:0] c, input logic eoi);
		src_t s;
		int   gap;
		s.ch           = c;
		s.end_of_input = eoi;
		gap = burst ? 0 : pick_idle();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_item  <= s;
		src_valid <= 1'b1;
		do
			@(posedge clk);
		while (!src_ready);
		predict_tokens(s);
		bytes_sent++;
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_src(text[i], 1'b0);
	endtask

	task automatic send_end();
		send_src(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("%0t: %s got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic test_punctuation_and_operators();
		// an operator cut short by punctuation gives two tokens in one step
		send_text(";:(){}+ += ++ - -= -- * *= ** / /= = == > >= < <= +-;x*/\n");
	endtask

	task automatic test_identifiers_and_keyword();
		send_text("var\tvar;var");
		send_src(CH_CR, 1'b0);
		send_text("var\n varx va vr var1 _Zz9 AZaz var(");
		send_text("var");
		send_end();
	endtask

	task automatic test_numbers();
		send_text("0 9876543210 3.25 1. . .5 12.34.5 7x\n");
	endtask

	task automatic test_literals();
		send_text("\"\" \"a b;\" 'x' '\"' ''' \"l1\nl2\"\n");
		send_src(CH_DQUOTE, 1'b0);
		send_src(8'hff, 1'b0);
		send_src(8'h00, 1'b0);
		send_src(CH_DQUOTE, 1'b0);
		// missing closing quote, then resync with a quoted stretch
		send_text("'ab;c 'a\"x;\";d\n");
	endtask

	task automatic test_directives();
		send_text("#fmain.src\n#f a\tx #q y #\n#ff");
		send_src(CH_CR, 1'b0);
		send_text("z\n");
	endtask

	task automatic test_errors_and_resync();
		send_src(8'h00, 1'b0);
		send_text(" a\n");
		send_src(8'hff, 1'b0);
		send_text("\"x;y\" z}w;@{$`~!?]k;");
	endtask

	task automatic test_end_of_input();
		send_end();
		send_text("abc");
		send_end();
		send_text("42.");
		send_end();
		send_text(">");
		send_end();
		send_text("-");
		send_end();
		send_text("\"open");
		send_end();
		send_text("'");
		send_end();
		send_text("'q");
		send_end();
		send_text("#");
		send_end();
		send_text("#fname");
		send_end();
		// end of input also leaves the quoted part of a resync
		send_text("?\"zz");
		send_end();
		send_text("\"s\" ");
	endtask

	// the wrapped index shows on the tokens that follow
	task automatic test_file_index_wrap();
		burst = 1'b1;
		repeat (258) send_text("#f ");
		send_text(";");
		burst = 1'b0;
	endtask

	task automatic test_random_source(input int count);
		string      word_chars = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
		string      op_chars = "+-*/=<>";
		string      punct_chars = ";:(){}";
		string      bad_chars = "@$!?~`^|&%,[]\\";
		logic [7:0] c;
		int         stop;
		stop = bytes_sent + count;
		while (bytes_sent < stop) begin
			case ($urandom_range(0, 15))
				0, 1: begin
					send_src(word_chars[$urandom_range(0, 52)], 1'b0);
					repeat ($urandom_range(0, 7))
						send_src(word_chars[$urandom_range(0, 62)], 1'b0);
				end
				2: begin
					send_text(($urandom_range(0, 3) == 0) ? "va" : "var");
					if ($urandom_range(0, 1) == 0)
						send_src(random_blank(), 1'b0);
					else
						send_src(8'($urandom_range(0, 255)), 1'b0);
				end
				3, 4: begin
					if ($urandom_range(0, 4) != 0)
						repeat ($urandom_range(1, 5))
							send_src(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
					if ($urandom_range(0, 2) == 0) begin
						send_src(CH_DOT, 1'b0);
						repeat ($urandom_range(0, 3))
							send_src(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
					end
				end
				5, 6: begin
					c = op_chars[$urandom_range(0, 6)];
					send_src(c, 1'b0);
					case ($urandom_range(0, 3))
						0:       send_src(CH_EQ, 1'b0);
						1:       send_src(c, 1'b0);
						default: ;
					endcase
				end
				7: send_src(punct_chars[$urandom_range(0, 5)], 1'b0);
				8: repeat ($urandom_range(1, 3)) send_src(random_blank(), 1'b0);
				9: begin
					send_src(CH_DQUOTE, 1'b0);
					repeat ($urandom_range(0, 8)) begin
						do
							c = 8'($urandom_range(0, 255));
						while (c == CH_DQUOTE);
						send_src(c, 1'b0);
					end
					if ($urandom_range(0, 9) != 0)
						send_src(CH_DQUOTE, 1'b0);
				end
				10: begin
					send_src(CH_SQUOTE, 1'b0);
					send_src(8'($urandom_range(0, 255)), 1'b0);
					if ($urandom_range(0, 4) != 0)
						send_src(CH_SQUOTE, 1'b0);
					else
						send_src(8'($urandom_range(0, 255)), 1'b0);
				end
				11: begin
					send_src(CH_HASH, 1'b0);
					if ($urandom_range(0, 2) != 0) begin
						send_src(CH_LOW_F, 1'b0);
						repeat ($urandom_range(0, 6))
							send_src(word_chars[$urandom_range(0, 62)], 1'b0);
						send_src(random_blank(), 1'b0);
					end else begin
						send_src(8'($urandom_range(0, 255)), 1'b0);
					end
				end
				12: send_src(bad_chars[$urandom_range(0, bad_chars.len() - 1)], 1'b0);
				13: repeat ($urandom_range(1, 3)) send_src(8'($urandom_range(0, 255)), 1'b0);
				14: begin
					if ($urandom_range(0, 3) == 0)
						send_end();
					else
						send_src(CH_SEMI, 1'b0);
				end
				default: send_src(random_blank(), 1'b0);
			endcase
			if ($urandom_range(0, 1) == 0)
				send_src(random_blank(), 1'b0);
		end
	endtask

	// alternate stretches with and without idling
	initial begin : idle_phases
		forever begin
			idle_on = 1'b1;
			repeat ($urandom_range(200, 800)) @(posedge clk);
			idle_on = 1'b0;
			repeat ($urandom_range(40, 200)) @(posedge clk);
		end
	end

	initial begin : tok_ready_pattern
		int stall;
		tok_ready = 1'b0;
		@(posedge clk);
		forever begin
			tok_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			stall = pick_idle();
			if (stall > 0) begin
				tok_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : token_check
		tok_t want;
		if (arst_n && tok_valid && tok_ready) begin
			if (expected_toks.size() == 0) begin
				report_mismatch("token transaction with none expected, kind",
					tok_item.token_kind, 'x);
			end else begin
				want = expected_toks.pop_front();
				if (tok_item.token_kind !== want.token_kind)
					report_mismatch("token_kind", tok_item.token_kind, want.token_kind);
				if (tok_item.error_code !== want.error_code)
					report_mismatch("error_code", tok_item.error_code, want.error_code);
				if (tok_item.start_pos !== want.start_pos)
					report_mismatch("start_pos", tok_item.start_pos, want.start_pos);
				if (tok_item.token_len !== want.token_len)
					report_mismatch("token_len", tok_item.token_len, want.token_len);
				if (tok_item.line_no !== want.line_no)
					report_mismatch("line_no", tok_item.line_no, want.line_no);
				if (tok_item.file_index !== want.file_index)
					report_mismatch("file_index", tok_item.file_index, want.file_index);
				if (tok_item.last !== want.last)
					report_mismatch("last", tok_item.last, want.last);
			end
		end
	end

	// cycles in which no transaction is taken on either side
	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (tok_valid && tok_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("source_token_lexer_top test failed");
			$finish;
		end
	end

	initial begin : main_sequence
		arst_n      = 1'b0;
		src_valid   = 1'b0;
		src_item    = '0;
		scan_mode   = M_IDLE;
		op_char     = 8'd0;
		tok_begin   = 24'd0;
		tok_size    = 16'd0;
		byte_pos    = 24'd0;
		line_num    = 16'd1;
		file_num    = 8'd0;
		var_match   = 2'd0;
		sync_quoted = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_punctuation_and_operators();
		test_identifiers_and_keyword();
		test_numbers();
		test_literals();
		test_directives();
		test_errors_and_resync();
		test_end_of_input();
		test_file_index_wrap();
		test_random_source(RANDOM_BYTES);
		src_valid <= 1'b0;
		while (expected_toks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("source_token_lexer_top test passed");
		else
			$display("source_token_lexer_top test failed");
		$finish;
	end

endmodule
